// ----- sv/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

    // Queue geometry
    localparam int CAPACITY     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int PRIO_BITS    = 8;
    localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

    // Request codes on the op field
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    // Result codes on the status field
    typedef enum logic [1:0] {
        ST_ADDED    = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // One stored entry
    typedef struct packed {
        logic        [PAYLOAD_BITS-1:0] payload;
        logic signed [PRIO_BITS-1:0]    prio;
    } entry_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t entry;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- sv/spq_cell.sv -----
`default_nettype none

// One slot of the sorted row. Compare the broadcast entry against the held
// one, then hold, load the new entry, take the left neighbor (insert shift)
// or take the right neighbor (remove shift).
module spq_cell
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_cmd_t cmd,
    input  wire logic      occ,
    input  wire logic      left_ge,
    input  wire entry_t    left_entry,
    input  wire entry_t    right_entry,
    output logic           ge,
    output entry_t         entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        ge = occ && ($signed(entry_reg.prio) >= $signed(cmd.entry.prio));
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert && !ge)
        begin
            entry_next = left_ge ? cmd.entry : left_entry;
        end
        else if (cmd.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ----- sv/sorted_priority_queue_unit.sv -----
`default_nettype none

// Sorted priority queue of CAPACITY entries built as a row of cells that
// keep entries in descending signed priority, front at cell 0. An enqueue
// lands behind every entry of greater or equal priority (equal priorities
// leave in arrival order); a dequeue returns the front entry. Every cell
// compares against the incoming priority at once and all cells shift together,
// so the unit takes one transfer per cycle, and each result appears in an
// output register in the cycle after its input transfer. The input stalls
// only while that register holds a result that the output side stalls.
// Dequeue on an empty queue reports empty; enqueue on a full queue is
// dropped and reports full. Each input item yields exactly one result.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           op,
    input  wire logic        [PAYLOAD_BITS-1:0] payload,
    input  wire logic signed [PRIO_BITS-1:0]    prio,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic             [1:0]              status,
    output logic             [PAYLOAD_BITS-1:0] out_payload,
    output logic signed      [PRIO_BITS-1:0]    out_prio,
    output logic             [COUNT_BITS-1:0]   fill
);

    // Control state
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // Result register (payload, no reset)
    status_t               status_reg;
    status_t               status_next;
    entry_t                res_reg;
    entry_t                res_next;
    logic [COUNT_BITS-1:0] fill_reg;

    logic                  in_fire;
    logic                  out_fire;
    logic                  is_deq;
    logic                  full;
    logic                  empty;
    cell_cmd_t             cmd;

    // Cell row wiring
    logic   [CAPACITY-1:0] ge_vec;
    logic   [CAPACITY-1:0] occ_vec;
    entry_t                ent_w [CAPACITY];

    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    assign is_deq = (op_t'(op) == OP_DEQ);
    assign full   = (count_reg == COUNT_BITS'(CAPACITY));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        cmd.insert        = in_fire && !is_deq && !full;
        cmd.remove        = in_fire && is_deq && !empty;
        cmd.entry.payload = payload;
        cmd.entry.prio    = prio;
    end

    // Row of cells; occupancy decodes from the fill count
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   left_ge_w;
        entry_t left_w;
        entry_t right_w;

        assign occ_vec[i] = (count_reg > COUNT_BITS'(i));

        if (i == 0)
        begin : g_front
            assign left_ge_w = 1'b1;
            assign left_w    = cmd.entry;
        end
        else
        begin : g_mid
            assign left_ge_w = ge_vec[i-1];
            assign left_w    = ent_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_back
            assign right_w = ent_w[i];
        end
        else
        begin : g_inner
            assign right_w = ent_w[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occ         (occ_vec[i]),
            .left_ge     (left_ge_w),
            .left_entry  (left_w),
            .right_entry (right_w),
            .ge          (ge_vec[i]),
            .entry       (ent_w[i])
        );
    end

    // Fill count and result selection
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_ADDED;
        res_next    = '0;
        if (is_deq)
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next = ST_DEQUEUED;
                res_next    = ent_w[0];
                count_next  = count_reg - COUNT_BITS'(1);
            end
        end
        else
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the result until its transfer; load a new one on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg <= status_next;
            res_reg    <= res_next;
            fill_reg   <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_payload = res_reg.payload;
    assign out_prio    = res_reg.prio;
    assign fill        = fill_reg;

    // Fill count never passes the row length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(CAPACITY))
        else $error("fill count above capacity");

    // Row stays sorted: a cell at or above the new priority implies its front neighbor is too
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ((ge_vec & ~{ge_vec[CAPACITY-2:0], 1'b1}) == '0))
        else $error("cell row out of order");

    // A pending result reports the count that the row holds
    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (fill_reg == count_reg))
        else $error("reported fill disagrees with count");

    // A dequeue result never comes out of an empty row
    a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_deq && empty) |=> (status_reg == ST_EMPTY && res_reg == '0))
        else $error("empty dequeue returned data");

endmodule

`default_nettype wire
